// File: hw/rtl/fscr_pkg.sv
// Package with the shared types and constants of the frame table replacer.
`default_nettype none
package fscr_pkg;

    localparam int NUM_FRAMES = 1024;
    localparam int MAX_REFS   = 63;
    localparam int ADDR_W     = $clog2(NUM_FRAMES);
    localparam int CNT_W      = ADDR_W + 1;
    localparam int REF_CAP    = (MAX_REFS < 63) ? MAX_REFS : 63;
    localparam int AGE_W      = 8;

    // Frame kinds.
    localparam logic [1:0] KIND_PAGE = 2'd0;
    localparam logic [1:0] KIND_DIR  = 2'd2;

    typedef enum logic [2:0] {
        CMD_ALLOC  = 3'd0,
        CMD_MAP    = 3'd1,
        CMD_FREE   = 3'd2,
        CMD_TOUCH  = 3'd3,
        CMD_LOOKUP = 3'd4
    } cmd_t;

    typedef struct packed {
        logic [2:0] command;
        logic [9:0] frame;
        logic [1:0] frame_type;
        logic [3:0] store_id;
        logic [7:0] store_page;
    } req_t;

    typedef struct packed {
        logic [9:0] result_frame;
        logic       found;
        logic       evicted;
        logic       status;
    } res_t;

    // One frame table entry; queued marks membership in the page queue.
    typedef struct packed {
        logic             queued;
        logic             mapped;
        logic [1:0]       kind;
        logic [5:0]       refs;
        logic [3:0]       owner_store;
        logic [7:0]       owner_page;
        logic             accessed;
        logic [AGE_W-1:0] age;
    } ent_t;

    typedef enum logic [4:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ALC_RD,
        ST_ALC_USE,
        ST_SC_FRD,
        ST_SC_FUSE,
        ST_SC_EUSE,
        ST_AG_FRD,
        ST_AG_FUSE,
        ST_AG_EUSE,
        ST_CLR_RD,
        ST_CLR_USE,
        ST_QR_RD,
        ST_QR_USE,
        ST_OP_RD,
        ST_OP_USE,
        ST_LK_RD,
        ST_LK_USE
    } state_t;

endpackage
`default_nettype wire

// File: hw/rtl/frame_table_second_chance_replacer_core.sv
// Top level of the frame table with second-chance or aging replacement.
`default_nettype none
// A request is taken when start is high and busy is low; its single result
// appears for one cycle with done high and cannot be stalled by the receiver.
// All work is done by one sequencer over two memories (entry table and page
// queue) with a registered read. Allocate with a free frame scans from
// frame 0 for the lowest free frame; lookup scans the same way, over all
// NUM_FRAMES frames. An eviction walks the queue (second chance up to
// count+1 steps, aging exactly count steps), then clears the victim and
// removes it from the queue. Map, free and touch work on one entry; a frame
// that leaves the queue is removed from it the same way. After reset, busy
// stays high while the entry table is cleared; policy writes are accepted
// only while busy is low.
module frame_table_second_chance_replacer_core (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    output logic               busy,
    input  wire fscr_pkg::req_t req,
    input  wire logic          cfg_valid,
    output logic               cfg_ready,
    input  wire logic          cfg_data,
    output logic               done,
    output fscr_pkg::res_t     result
);

    localparam int AW = fscr_pkg::ADDR_W;
    localparam int CW = fscr_pkg::CNT_W;
    localparam int EW = $bits(fscr_pkg::ent_t);

    fscr_pkg::state_t state_reg, state_next;
    logic [CW-1:0]    idx_reg, idx_next;
    logic [CW-1:0]    count_reg, count_next;
    logic [AW-1:0]    frm_reg, frm_next;
    logic [AW-1:0]    victim_reg, victim_next;
    logic [fscr_pkg::AGE_W:0] best_age_reg, best_age_next;
    logic             hit_reg, hit_next;
    logic             policy_reg;
    fscr_pkg::req_t   req_reg, req_next;
    fscr_pkg::res_t   res_reg, res_next;
    logic             done_reg, done_next;

    logic             ent_we;
    logic [AW-1:0]    ent_waddr, ent_raddr;
    fscr_pkg::ent_t   ent_wdata, ent_rd;
    logic [EW-1:0]    ent_rdata;
    logic             fifo_we;
    logic [AW-1:0]    fifo_waddr, fifo_raddr;
    logic [AW-1:0]    fifo_wdata, fifo_rdata;

    logic [fscr_pkg::AGE_W-1:0] new_age;
    logic [5:0]       dec_refs;

    assign ent_rd = fscr_pkg::ent_t'(ent_rdata);

    fscr_ram #(.WIDTH(EW), .DEPTH(fscr_pkg::NUM_FRAMES)) u_ent_ram (
        .clk   (clk),
        .we    (ent_we),
        .waddr (ent_waddr),
        .wdata (ent_wdata),
        .raddr (ent_raddr),
        .rdata (ent_rdata)
    );

    fscr_ram #(.WIDTH(AW), .DEPTH(fscr_pkg::NUM_FRAMES)) u_fifo_ram (
        .clk   (clk),
        .we    (fifo_we),
        .waddr (fifo_waddr),
        .wdata (fifo_wdata),
        .raddr (fifo_raddr),
        .rdata (fifo_rdata)
    );

    assign busy      = (state_reg != fscr_pkg::ST_IDLE);
    assign cfg_ready = (state_reg == fscr_pkg::ST_IDLE);
    assign done      = done_reg;
    assign result    = res_reg;

    // Policy register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            policy_reg <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            policy_reg <= cfg_data;
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= fscr_pkg::ST_CLEAR;
            idx_reg   <= '0;
            count_reg <= '0;
            hit_reg   <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            count_reg <= count_next;
            hit_reg   <= hit_next;
            done_reg  <= done_next;
        end
    end

    // Working payload.
    always_ff @(posedge clk)
    begin
        frm_reg      <= frm_next;
        victim_reg   <= victim_next;
        best_age_reg <= best_age_next;
        req_reg      <= req_next;
        res_reg      <= res_next;
    end

    // Aging value and decremented reference count of the entry just read.
    assign new_age  = {ent_rd.accessed, ent_rd.age[fscr_pkg::AGE_W-1:1]};
    assign dec_refs = (ent_rd.refs != 6'd0) ? ent_rd.refs - 6'd1 : 6'd0;

    // Sequencer.
    always_comb
    begin
        state_next    = state_reg;
        idx_next      = idx_reg;
        count_next    = count_reg;
        frm_next      = frm_reg;
        victim_next   = victim_reg;
        best_age_next = best_age_reg;
        hit_next      = hit_reg;
        req_next      = req_reg;
        res_next      = res_reg;
        done_next     = 1'b0;
        ent_we        = 1'b0;
        ent_waddr     = frm_reg;
        ent_wdata     = ent_rd;
        ent_raddr     = frm_reg;
        fifo_we       = 1'b0;
        fifo_waddr    = count_reg[AW-1:0];
        fifo_wdata    = frm_reg;
        fifo_raddr    = idx_reg[AW-1:0];

        unique case (state_reg)
            fscr_pkg::ST_CLEAR:
            begin
                ent_we    = 1'b1;
                ent_waddr = idx_reg[AW-1:0];
                ent_wdata = '0;
                if (idx_reg == CW'(fscr_pkg::NUM_FRAMES - 1))
                begin
                    idx_next   = '0;
                    state_next = fscr_pkg::ST_IDLE;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end

            fscr_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    req_next = req;
                    res_next = '0;
                    idx_next = '0;
                    frm_next = req.frame[AW-1:0];
                    case (fscr_pkg::cmd_t'(req.command))
                        fscr_pkg::CMD_ALLOC:
                        begin
                            state_next = fscr_pkg::ST_ALC_RD;
                        end
                        fscr_pkg::CMD_MAP, fscr_pkg::CMD_FREE, fscr_pkg::CMD_TOUCH:
                        begin
                            if ({1'b0, req.frame} < 11'(fscr_pkg::NUM_FRAMES))
                            begin
                                state_next = fscr_pkg::ST_OP_RD;
                            end
                            else
                            begin
                                done_next = 1'b1;
                            end
                        end
                        fscr_pkg::CMD_LOOKUP:
                        begin
                            state_next = fscr_pkg::ST_LK_RD;
                        end
                        default:
                        begin
                            done_next = 1'b1;
                        end
                    endcase
                end
            end

            // Search for the lowest unmapped frame.
            fscr_pkg::ST_ALC_RD:
            begin
                ent_raddr  = idx_reg[AW-1:0];
                state_next = fscr_pkg::ST_ALC_USE;
            end

            fscr_pkg::ST_ALC_USE:
            begin
                if (!ent_rd.mapped)
                begin
                    res_next.result_frame = 10'(idx_reg[AW-1:0]);
                    done_next  = 1'b1;
                    state_next = fscr_pkg::ST_IDLE;
                end
                else if (idx_reg == CW'(fscr_pkg::NUM_FRAMES - 1))
                begin
                    idx_next = '0;
                    if (count_reg == '0)
                    begin
                        res_next.status = 1'b1;
                        done_next  = 1'b1;
                        state_next = fscr_pkg::ST_IDLE;
                    end
                    else if (policy_reg)
                    begin
                        best_age_next = {1'b1, {fscr_pkg::AGE_W{1'b0}}};
                        state_next    = fscr_pkg::ST_AG_FRD;
                    end
                    else
                    begin
                        state_next = fscr_pkg::ST_SC_FRD;
                    end
                end
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = fscr_pkg::ST_ALC_RD;
                end
            end

            // Second chance walk around the queue.
            fscr_pkg::ST_SC_FRD:
            begin
                state_next = fscr_pkg::ST_SC_FUSE;
            end

            fscr_pkg::ST_SC_FUSE:
            begin
                frm_next   = fifo_rdata;
                ent_raddr  = fifo_rdata;
                state_next = fscr_pkg::ST_SC_EUSE;
            end

            fscr_pkg::ST_SC_EUSE:
            begin
                if (!ent_rd.accessed)
                begin
                    victim_next = frm_reg;
                    state_next  = fscr_pkg::ST_CLR_RD;
                end
                else
                begin
                    ent_we             = 1'b1;
                    ent_wdata.accessed = 1'b0;
                    idx_next   = (idx_reg + 1'b1 == count_reg) ? '0 : idx_reg + 1'b1;
                    state_next = fscr_pkg::ST_SC_FRD;
                end
            end

            // Aging pass: update every age and keep the earliest minimum.
            fscr_pkg::ST_AG_FRD:
            begin
                state_next = fscr_pkg::ST_AG_FUSE;
            end

            fscr_pkg::ST_AG_FUSE:
            begin
                frm_next   = fifo_rdata;
                ent_raddr  = fifo_rdata;
                state_next = fscr_pkg::ST_AG_EUSE;
            end

            fscr_pkg::ST_AG_EUSE:
            begin
                ent_we             = 1'b1;
                ent_wdata.accessed = 1'b0;
                ent_wdata.age      = new_age;
                if ({1'b0, new_age} < best_age_reg)
                begin
                    best_age_next = {1'b0, new_age};
                    victim_next   = frm_reg;
                end
                if (idx_reg + 1'b1 == count_reg)
                begin
                    state_next = fscr_pkg::ST_CLR_RD;
                end
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = fscr_pkg::ST_AG_FRD;
                end
            end

            // Clear the victim entry; an allocate reports it as evicted.
            fscr_pkg::ST_CLR_RD:
            begin
                ent_raddr  = victim_reg;
                state_next = fscr_pkg::ST_CLR_USE;
                if (req_reg.command == fscr_pkg::CMD_ALLOC)
                begin
                    res_next.result_frame = 10'(victim_reg);
                    res_next.evicted      = 1'b1;
                end
            end

            fscr_pkg::ST_CLR_USE:
            begin
                ent_we             = 1'b1;
                ent_waddr          = victim_reg;
                ent_wdata.queued   = 1'b0;
                ent_wdata.mapped   = 1'b0;
                ent_wdata.refs     = '0;
                ent_wdata.accessed = 1'b0;
                ent_wdata.age      = '0;
                if (ent_rd.queued)
                begin
                    idx_next   = '0;
                    hit_next   = 1'b0;
                    state_next = fscr_pkg::ST_QR_RD;
                end
                else
                begin
                    done_next  = 1'b1;
                    state_next = fscr_pkg::ST_IDLE;
                end
            end

            // Remove the victim from the queue, shifting later slots down.
            fscr_pkg::ST_QR_RD:
            begin
                state_next = fscr_pkg::ST_QR_USE;
            end

            fscr_pkg::ST_QR_USE:
            begin
                if (hit_reg)
                begin
                    fifo_we    = 1'b1;
                    fifo_waddr = idx_reg[AW-1:0] - 1'b1;
                    fifo_wdata = fifo_rdata;
                end
                else if (fifo_rdata == victim_reg)
                begin
                    hit_next = 1'b1;
                end
                if (idx_reg + 1'b1 == count_reg)
                begin
                    count_next = count_reg - 1'b1;
                    done_next  = 1'b1;
                    state_next = fscr_pkg::ST_IDLE;
                end
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = fscr_pkg::ST_QR_RD;
                end
            end

            // Map, free and touch on one entry.
            fscr_pkg::ST_OP_RD:
            begin
                state_next = fscr_pkg::ST_OP_USE;
            end

            fscr_pkg::ST_OP_USE:
            begin
                done_next  = 1'b1;
                state_next = fscr_pkg::ST_IDLE;
                case (fscr_pkg::cmd_t'(req_reg.command))
                    fscr_pkg::CMD_MAP:
                    begin
                        ent_we                = 1'b1;
                        ent_wdata.mapped      = 1'b1;
                        ent_wdata.kind        = req_reg.frame_type;
                        ent_wdata.owner_store = req_reg.store_id;
                        ent_wdata.owner_page  = req_reg.store_page;
                        if (ent_rd.refs < 6'(fscr_pkg::REF_CAP))
                        begin
                            ent_wdata.refs = ent_rd.refs + 6'd1;
                        end
                        if (req_reg.frame_type == fscr_pkg::KIND_PAGE)
                        begin
                            if (!ent_rd.queued)
                            begin
                                fifo_we          = 1'b1;
                                count_next       = count_reg + 1'b1;
                                ent_wdata.queued = 1'b1;
                                ent_wdata.age    = '0;
                            end
                        end
                        else if (ent_rd.queued)
                        begin
                            ent_wdata.queued = 1'b0;
                            victim_next      = frm_reg;
                            idx_next         = '0;
                            hit_next         = 1'b0;
                            done_next        = 1'b0;
                            state_next       = fscr_pkg::ST_QR_RD;
                        end
                    end
                    fscr_pkg::CMD_FREE:
                    begin
                        if (ent_rd.mapped)
                        begin
                            if (ent_rd.kind == fscr_pkg::KIND_DIR || dec_refs == 6'd0)
                            begin
                                res_next.found = 1'b1;
                                victim_next    = frm_reg;
                                done_next      = 1'b0;
                                state_next     = fscr_pkg::ST_CLR_RD;
                            end
                            else
                            begin
                                ent_we         = 1'b1;
                                ent_wdata.refs = dec_refs;
                            end
                        end
                    end
                    fscr_pkg::CMD_TOUCH:
                    begin
                        ent_we             = 1'b1;
                        ent_wdata.accessed = 1'b1;
                    end
                    default:
                    begin
                        ent_we = 1'b0;
                    end
                endcase
            end

            // Lookup scan by owner.
            fscr_pkg::ST_LK_RD:
            begin
                ent_raddr  = idx_reg[AW-1:0];
                state_next = fscr_pkg::ST_LK_USE;
            end

            fscr_pkg::ST_LK_USE:
            begin
                if (ent_rd.mapped && ent_rd.owner_store == req_reg.store_id
                    && ent_rd.owner_page == req_reg.store_page)
                begin
                    res_next.result_frame = 10'(idx_reg[AW-1:0]);
                    res_next.found        = 1'b1;
                    done_next  = 1'b1;
                    state_next = fscr_pkg::ST_IDLE;
                end
                else if (idx_reg == CW'(fscr_pkg::NUM_FRAMES - 1))
                begin
                    done_next  = 1'b1;
                    state_next = fscr_pkg::ST_IDLE;
                end
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = fscr_pkg::ST_LK_RD;
                end
            end

            default:
            begin
                state_next = fscr_pkg::ST_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

// File: hw/rtl/fscr_ram.sv
// Simple dual-port RAM with one write port and one registered read port.
`default_nettype none
module fscr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire
